// File: hdl/wuvp_pkg.sv
// Shared types, constants and elaboration-time functions for the wind vector to polar converter.
`timescale 1ns / 1ps

package wuvp_pkg;

    // Component format and CORDIC datapath widths.
    localparam int COMPONENT_WIDTH       = 16;
    localparam int CORDIC_STAGES_DEFAULT = 16;
    localparam int CORDIC_STAGES_MAX     = 24;
    localparam int CORDIC_BASE_W         = 32;
    localparam int GUARD_BITS            = CORDIC_BASE_W - COMPONENT_WIDTH;
    localparam int XY_W                  = CORDIC_BASE_W + 3;
    localparam int Z_W                   = 25;

    // Angles are degrees in Q16.
    localparam int ANGLE_FRAC    = 16;
    localparam int ANGLE_ONE_DEG = 1 << ANGLE_FRAC;
    localparam int QUARTER_Q16   = 90 * ANGLE_ONE_DEG;
    localparam int TOTAL_W       = 25;
    localparam int DIR_Q7_SHIFT  = ANGLE_FRAC - 7;
    localparam int DIR_Q7_W      = TOTAL_W - DIR_Q7_SHIFT;

    // Result field widths.
    localparam int DIR_W     = 9;
    localparam int SECTOR_W  = 3;
    localparam int MAG_W     = 16;
    localparam int KNOTS_W   = 9;
    localparam int NUM_BOUNDS = 8;

    // Inverse CORDIC gain in Q31 and the knots factor 1.94384 in Q16.
    localparam int GAIN_W    = 31;
    localparam int GAIN_FRAC = 31;
    localparam int KNOT_Q16  = 127392;
    localparam int KNOT_W    = 17;
    localparam int KNOT_FRAC = 24;

    // Arctangent of 2^-i in degrees Q16, rounded to nearest.
    localparam int ATAN_DEG_Q16 [CORDIC_STAGES_MAX] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    // Upper bounds of the compass sectors in whole degrees.
    localparam int SECTOR_BOUND_DEG [NUM_BOUNDS] = '{22, 67, 112, 157, 202, 247, 292, 337};

    // Rotation applied when the vector is folded into the first quadrant.
    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } quadrant_t;

    // Input word: the two wind components.
    typedef struct packed {
        logic signed [COMPONENT_WIDTH-1:0] wind_u;
        logic signed [COMPONENT_WIDTH-1:0] wind_v;
    } uv_word_t;

    // Result word.
    typedef struct packed {
        logic [DIR_W-1:0]    direction_deg;
        logic [SECTOR_W-1:0] compass_sector;
        logic [MAG_W-1:0]    speed_mag;
        logic [KNOTS_W-1:0]  speed_knots;
        logic                calm;
    } polar_word_t;

    // Word carried along the CORDIC pipeline.
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        quadrant_t              quad;
        logic                   calm;
    } cordic_word_t;

    // Integer square root, one result bit per iteration.
    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        int          k;
        n = n_in;
        r = '0;
        b = 64'd1 << 62;
        for (k = 0; k < 32; k++) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Product of the per-iteration inverse gains in Q31, by restoring long division.
    function automatic logic [63:0] inverse_gain_q31(input int stages);
        logic [63:0] g;
        logic [63:0] s;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] quo;
        int          i;
        int          k;
        g = 64'd1 << 31;
        for (i = 0; i < CORDIC_STAGES_MAX; i++) begin
            if (i < stages) begin
                s   = isqrt64((64'd1 << 62) + (64'd1 << (62 - 2 * i)));
                num = g << 31;
                rem = '0;
                quo = '0;
                for (k = 63; k >= 0; k--) begin
                    rem = {rem[62:0], num[k]};
                    if (rem >= s) begin
                        rem    = rem - s;
                        quo[k] = 1'b1;
                    end
                end
                g = quo;
            end
        end
        return g;
    endfunction

endpackage

// File: hdl/wuvp_fold.sv
// Input stage: folds the wind vector into the first quadrant and scales it for the CORDIC.
`timescale 1ns / 1ps

module wuvp_fold (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  wuvp_pkg::uv_word_t      s_word,
    output logic                    out_valid,
    input  logic                    out_ready,
    output wuvp_pkg::cordic_word_t  out_word
);
    import wuvp_pkg::*;

    logic signed [COMPONENT_WIDTH:0] neg_u;
    logic signed [COMPONENT_WIDTH:0] neg_v;
    logic signed [COMPONENT_WIDTH:0] fold_x;
    logic signed [COMPONENT_WIDTH:0] fold_y;
    quadrant_t                       fold_quad;
    cordic_word_t                    word_next;
    cordic_word_t                    word_reg;
    logic                            valid_reg;

    // The from-direction vector is (-v, -u); rotate it so that x > 0 and y >= 0 for any nonzero vector.
    always_comb begin
        neg_u = -((COMPONENT_WIDTH + 1)'(s_word.wind_u));
        neg_v = -((COMPONENT_WIDTH + 1)'(s_word.wind_v));
        if (neg_v > 0 && neg_u >= 0) begin
            fold_x    = neg_v;
            fold_y    = neg_u;
            fold_quad = QUAD_0;
        end else if (neg_v <= 0 && neg_u > 0) begin
            fold_x    = neg_u;
            fold_y    = -neg_v;
            fold_quad = QUAD_90;
        end else if (neg_v < 0 && neg_u <= 0) begin
            fold_x    = -neg_v;
            fold_y    = -neg_u;
            fold_quad = QUAD_180;
        end else begin
            fold_x    = -neg_u;
            fold_y    = neg_v;
            fold_quad = QUAD_270;
        end
    end

    // Scale the folded components up by the guard bits.
    always_comb begin
        word_next.x    = XY_W'(fold_x) <<< GUARD_BITS;
        word_next.y    = XY_W'(fold_y) <<< GUARD_BITS;
        word_next.z    = '0;
        word_next.quad = fold_quad;
        word_next.calm = (s_word.wind_u == '0) && (s_word.wind_v == '0);
    end

    assign s_ready = !valid_reg || out_ready;

    // Stage register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// File: hdl/wuvp_cordic_stage.sv
// One CORDIC vectoring iteration with its pipeline register.
`timescale 1ns / 1ps

module wuvp_cordic_stage #(
    parameter int SHIFT = 0
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  wuvp_pkg::cordic_word_t  in_word,
    output logic                    out_valid,
    input  logic                    out_ready,
    output wuvp_pkg::cordic_word_t  out_word
);
    import wuvp_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN_STEP = Z_W'(ATAN_DEG_Q16[SHIFT]);

    logic signed [XY_W-1:0] x_cur;
    logic signed [XY_W-1:0] y_cur;
    logic signed [XY_W-1:0] x_shift;
    logic signed [XY_W-1:0] y_shift;
    cordic_word_t           word_next;
    cordic_word_t           word_reg;
    logic                   valid_reg;

    // Rotate toward the x axis; the angle accumulator tracks the rotation.
    always_comb begin
        x_cur     = in_word.x;
        y_cur     = in_word.y;
        x_shift   = x_cur >>> SHIFT;
        y_shift   = y_cur >>> SHIFT;
        word_next = in_word;
        if (y_cur > 0) begin
            word_next.x = x_cur + y_shift;
            word_next.y = y_cur - x_shift;
            word_next.z = in_word.z + ATAN_STEP;
        end else begin
            word_next.x = x_cur - y_shift;
            word_next.y = y_cur + x_shift;
            word_next.z = in_word.z - ATAN_STEP;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // Stage register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// File: hdl/wuvp_post.sv
// Back end: angle offset, gain correction, sector, knots and the output register.
`timescale 1ns / 1ps

module wuvp_post #(
    parameter int CORDIC_STAGES = wuvp_pkg::CORDIC_STAGES_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  wuvp_pkg::cordic_word_t  in_word,
    output logic                    m_valid,
    input  logic                    m_ready,
    output wuvp_pkg::polar_word_t   m_word
);
    import wuvp_pkg::*;

    localparam logic [GAIN_W-1:0] INV_GAIN = GAIN_W'(inverse_gain_q31(CORDIC_STAGES));
    localparam int MX_W        = XY_W - 1;
    localparam int LO_W        = MX_W / 2;
    localparam int HI_W        = MX_W - LO_W;
    localparam int PPL_W       = LO_W + GAIN_W;
    localparam int PPH_W       = HI_W + GAIN_W;
    localparam int PROD_W      = MX_W + GAIN_W + 1;
    localparam int ROUND_SHIFT = GAIN_FRAC + GUARD_BITS;
    localparam int KP_W        = MAG_W + KNOT_W + 1;
    localparam logic [TOTAL_W-1:0] ANGLE_MAX = TOTAL_W'(QUARTER_Q16 - 1);

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [PPL_W-1:0]   pp_lo;
        logic [PPH_W-1:0]   pp_hi;
        logic               calm;
    } p1_word_t;

    typedef struct packed {
        logic [DIR_W-1:0]    direction;
        logic [SECTOR_W-1:0] sector;
        logic [MAG_W-1:0]    mag;
        logic                calm;
    } p2_word_t;

    logic [TOTAL_W-1:0]  z_clamped;
    logic [TOTAL_W-1:0]  angle_offset;
    logic [MX_W-1:0]     x_clamped;
    p1_word_t            p1_next;
    p1_word_t            p1_reg;
    logic                p1_valid_reg;
    logic                p1_ready;

    logic [PROD_W-1:0]   prod_sum;
    logic [PROD_W-1:0]   mag_wide;
    logic [DIR_Q7_W-1:0] dir_q7;
    logic [SECTOR_W-1:0] sector_count;
    p2_word_t            p2_next;
    p2_word_t            p2_reg;
    logic                p2_valid_reg;
    logic                p2_ready;

    logic [KP_W-1:0]     knot_sum;
    logic [KP_W-1:0]     knots_wide;
    polar_word_t         out_next;
    polar_word_t         out_reg;
    logic                out_valid_reg;
    logic                out_ready;

    // Ready chain: a stage takes a word when it is empty or its word moves on.
    assign out_ready = !out_valid_reg || m_ready;
    assign p2_ready  = !p2_valid_reg || out_ready;
    assign p1_ready  = !p1_valid_reg || p2_ready;
    assign in_ready  = p1_ready;

    // Stage 1: clamp the angle, add the quadrant offset, start the gain multiply.
    always_comb begin
        if (in_word.z < 0) begin
            z_clamped = '0;
        end else if (TOTAL_W'(in_word.z) > ANGLE_MAX) begin
            z_clamped = ANGLE_MAX;
        end else begin
            z_clamped = TOTAL_W'(in_word.z);
        end
        case (in_word.quad)
            QUAD_0:   angle_offset = '0;
            QUAD_90:  angle_offset = TOTAL_W'(QUARTER_Q16);
            QUAD_180: angle_offset = TOTAL_W'(2 * QUARTER_Q16);
            QUAD_270: angle_offset = TOTAL_W'(3 * QUARTER_Q16);
            default:  angle_offset = '0;
        endcase
        if (in_word.x[XY_W-1]) begin
            x_clamped = '0;
        end else begin
            x_clamped = in_word.x[MX_W-1:0];
        end
        p1_next.total = z_clamped + angle_offset;
        p1_next.pp_lo = PPL_W'(x_clamped[LO_W-1:0]) * PPL_W'(INV_GAIN);
        p1_next.pp_hi = PPH_W'(x_clamped[MX_W-1:LO_W]) * PPH_W'(INV_GAIN);
        p1_next.calm  = in_word.calm;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (p1_ready) begin
            p1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_ready && in_valid) begin
            p1_reg <= p1_next;
        end
    end

    // Stage 2: finish the magnitude with rounding, derive direction and sector.
    always_comb begin
        prod_sum = (PROD_W'(p1_reg.pp_hi) << LO_W) + PROD_W'(p1_reg.pp_lo)
                 + (PROD_W'(1) << (ROUND_SHIFT - 1));
        mag_wide = prod_sum >> ROUND_SHIFT;
        if (mag_wide > PROD_W'({MAG_W{1'b1}})) begin
            p2_next.mag = {MAG_W{1'b1}};
        end else begin
            p2_next.mag = mag_wide[MAG_W-1:0];
        end
        dir_q7       = p1_reg.total[TOTAL_W-1:DIR_Q7_SHIFT];
        sector_count = '0;
        for (int k = 0; k < NUM_BOUNDS; k++) begin
            if (dir_q7 > DIR_Q7_W'(SECTOR_BOUND_DEG[k] * 128)) begin
                sector_count = sector_count + SECTOR_W'(1);
            end
        end
        p2_next.sector    = sector_count;
        p2_next.direction = p1_reg.total[ANGLE_FRAC +: DIR_W];
        p2_next.calm      = p1_reg.calm;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (p2_ready) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p2_ready && p1_valid_reg) begin
            p2_reg <= p2_next;
        end
    end

    // Stage 3: knots conversion and the calm override into the output register.
    always_comb begin
        knot_sum   = KP_W'(p2_reg.mag) * KP_W'(KNOT_Q16) + (KP_W'(1) << (KNOT_FRAC - 1));
        knots_wide = knot_sum >> KNOT_FRAC;
        if (p2_reg.calm) begin
            out_next = '0;
            out_next.calm = 1'b1;
        end else begin
            out_next.direction_deg  = p2_reg.direction;
            out_next.compass_sector = p2_reg.sector;
            out_next.speed_mag      = p2_reg.mag;
            if (knots_wide > KP_W'({KNOTS_W{1'b1}})) begin
                out_next.speed_knots = {KNOTS_W{1'b1}};
            end else begin
                out_next.speed_knots = knots_wide[KNOTS_W-1:0];
            end
            out_next.calm = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && p2_valid_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_reg;

`ifndef SYNTHESIS
    // A calm word carries zeros in every other field.
    a_calm_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.calm |-> m_word.direction_deg == '0 && m_word.speed_mag == '0
            && m_word.speed_knots == '0 && m_word.compass_sector == '0)
        else $error("calm word with nonzero fields");

    // The direction stays on the circle.
    a_dir_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_word.direction_deg < DIR_W'(360))
        else $error("direction out of range");

    // Directions strictly inside the northeast sector report that sector.
    a_sector_ne: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_word.calm && m_word.direction_deg >= DIR_W'(23)
            && m_word.direction_deg <= DIR_W'(66) |-> m_word.compass_sector == SECTOR_W'(1))
        else $error("sector disagrees with direction");

    // Zero magnitude gives zero knots.
    a_knots_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.speed_mag == '0 |-> m_word.speed_knots == '0)
        else $error("knots without magnitude");

    // A stalled first stage keeps its word.
    a_p1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg && !p2_ready |=> p1_valid_reg && $stable(p1_reg))
        else $error("stage one word lost under stall");
`endif

endmodule

// File: hdl/wind_uv_to_polar_core.sv
// Top level of the wind vector to direction, speed and compass sector converter.
`timescale 1ns / 1ps

// Usage:
//   The s_ channel takes one word per accepted handshake: the eastward and
//   northward wind components, signed Q8.8 m/s. The m_ channel returns one
//   word per input, in order: the direction the wind comes from in whole
//   degrees, the 8-point compass sector, the speed magnitude in Q8.8 m/s,
//   the speed in knots and a calm flag for a zero vector.
//   The pipeline has one fold stage, one register stage per CORDIC
//   iteration, and three back-end stages for angle offset and gain
//   multiply, magnitude rounding and sector, and knots.
//   Throughput is one word per cycle; every stage holds a register with its
//   own valid bit, so a new word enters each cycle the pipeline moves.
//   When m_ready is low the output register holds its word; earlier stages
//   keep filling any empty slots, and s_ready drops only once every stage
//   holds a word. No word is dropped or repeated under stall.
//   Synchronous reset clears all valid bits; the data registers are not reset.
module wind_uv_to_polar_core #(
    parameter int CORDIC_STAGES = wuvp_pkg::CORDIC_STAGES_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  wuvp_pkg::uv_word_t    s_word,
    output logic                  m_valid,
    input  logic                  m_ready,
    output wuvp_pkg::polar_word_t m_word
);
    import wuvp_pkg::*;

    cordic_word_t chain_word  [CORDIC_STAGES + 1];
    logic         chain_valid [CORDIC_STAGES + 1];
    logic         chain_ready [CORDIC_STAGES + 1];

    // Quadrant fold and guard scaling.
    wuvp_fold u_fold (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_word  (chain_word[0])
    );

    // CORDIC vectoring, one iteration per stage.
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        wuvp_cordic_stage #(
            .SHIFT (i)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_word   (chain_word[i]),
            .out_valid (chain_valid[i + 1]),
            .out_ready (chain_ready[i + 1]),
            .out_word  (chain_word[i + 1])
        );
    end

    // Gain correction, sector, knots and the output register.
    wuvp_post #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_post (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (chain_valid[CORDIC_STAGES]),
        .in_ready (chain_ready[CORDIC_STAGES]),
        .in_word  (chain_word[CORDIC_STAGES]),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_word   (m_word)
    );

endmodule
